>>> design/lamc_pkg.sv
// shared types and constants for the lift assist mode controller
`default_nettype none

package lamc_pkg;

  // field widths
  localparam int unsigned ROLL_W    = 13;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned TICKS_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;

  // default depth of the sample windows
  localparam int unsigned AVG_DEPTH_DEF = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_RATE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TICKS  = 3'd5;

  // register reset values
  localparam logic signed [ROLL_W-1:0] BAND_HIGH_RST  = 13'sd1200;
  localparam logic signed [ROLL_W-1:0] BAND_LOW_RST   = -13'sd1440;
  localparam logic signed [RATE_W-1:0] STILL_RATE_RST = 16'sd160;
  localparam logic [TICKS_W-1:0]       LOCK_TICKS_RST = 10'd200;

  // ten motor turns of 16384 counts
  localparam logic signed [POS_W:0]    LIFT_OFFSET = 33'sd163840;
  // upright roll in sixteenths of a degree
  localparam logic signed [ROLL_W:0]   STAND_ROLL  = 14'sd1440;
  // follow gain is 4096 / 9 counts per roll step
  localparam int unsigned              LOCK_DIV    = 9;
  localparam logic [CNT_W-1:0]         CNT_MAX     = '1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_LIFT,
    MODE_LOCK_DETECT,
    MODE_LOCK
  } mode_t;

  typedef enum logic [1:0] {
    PRED_NONE,
    PRED_MISSING,
    PRED_LIFTING,
    PRED_FAST
  } pred_t;

  typedef enum logic [1:0] {
    MOVE_NONE,
    MOVE_RELEASE,
    MOVE_LIFT,
    MOVE_FOLLOW
  } move_t;

  // decision handed from the mode controller to the target stage
  typedef struct packed {
    move_t                     move;
    mode_t                     mode;
    logic                      missing;
    logic signed [ROLL_W-1:0]  avg_roll;
  } job_t;

endpackage

`default_nettype wire

>>> design/lamc_window.sv
// sample windows for roll and gyro rate with running sums and rounded averages
`default_nettype none

module lamc_window #(
  parameter int unsigned AVG_DEPTH = lamc_pkg::AVG_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               sample_fire,
  input  wire logic signed [lamc_pkg::ROLL_W-1:0] roll_sample,
  input  wire logic signed [lamc_pkg::RATE_W-1:0] rate_sample,
  output logic signed [lamc_pkg::ROLL_W-1:0]      avg_roll,
  output logic signed [lamc_pkg::RATE_W-1:0]      avg_rate
);
  import lamc_pkg::*;

  localparam int unsigned RSUM_W = ROLL_W + $clog2(AVG_DEPTH);
  localparam int unsigned GSUM_W = RATE_W + $clog2(AVG_DEPTH);
  localparam int unsigned RQ_W   = RSUM_W + 1;
  localparam int unsigned GQ_W   = GSUM_W + 1;
  localparam int unsigned RSH    = RQ_W + $clog2(AVG_DEPTH);
  localparam int unsigned GSH    = GQ_W + $clog2(AVG_DEPTH);
  localparam logic [RSUM_W:0] RHALF = (RSUM_W+1)'(AVG_DEPTH / 2);
  localparam logic [GSUM_W:0] GHALF = (GSUM_W+1)'(AVG_DEPTH / 2);
  // reciprocals of the depth, exact over the whole rounded magnitude range
  localparam logic [RSH-1:0] RMUL =
    RSH'(((64'd1 << RSH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
  localparam logic [GSH-1:0] GMUL =
    GSH'(((64'd1 << GSH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  logic signed [ROLL_W-1:0] roll_win_r [AVG_DEPTH];
  logic signed [RATE_W-1:0] rate_win_r [AVG_DEPTH];
  logic signed [RSUM_W-1:0] roll_sum_r, roll_sum_nxt;
  logic signed [GSUM_W-1:0] rate_sum_r, rate_sum_nxt;

  logic                   roll_neg, rate_neg;
  logic [RSUM_W-1:0]      roll_mag;
  logic [GSUM_W-1:0]      rate_mag;
  logic [RSUM_W:0]        roll_rnd;
  logic [GSUM_W:0]        rate_rnd;
  logic [RQ_W+RSH-1:0]    roll_prod;
  logic [GQ_W+GSH-1:0]    rate_prod;
  logic [RSUM_W:0]        roll_quo;
  logic [GSUM_W:0]        rate_quo;

  // running sums drop the oldest entry and add the new one
  assign roll_sum_nxt = roll_sum_r - RSUM_W'(roll_win_r[0]) + RSUM_W'(roll_sample);
  assign rate_sum_nxt = rate_sum_r - GSUM_W'(rate_win_r[0]) + GSUM_W'(rate_sample);

  // window shift on each sample transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        roll_win_r[i] <= '0;
        rate_win_r[i] <= '0;
      end
      roll_sum_r <= '0;
      rate_sum_r <= '0;
    end else if (sample_fire) begin
      for (int i = 0; i < AVG_DEPTH - 1; i++) begin
        roll_win_r[i] <= roll_win_r[i+1];
        rate_win_r[i] <= rate_win_r[i+1];
      end
      roll_win_r[AVG_DEPTH-1] <= roll_sample;
      rate_win_r[AVG_DEPTH-1] <= rate_sample;
      roll_sum_r <= roll_sum_nxt;
      rate_sum_r <= rate_sum_nxt;
    end
  end

  // round half away from zero on the magnitude, divide by reciprocal multiply
  always_comb begin
    roll_neg  = roll_sum_r[RSUM_W-1];
    rate_neg  = rate_sum_r[GSUM_W-1];
    roll_mag  = roll_neg ? RSUM_W'(-roll_sum_r) : RSUM_W'(roll_sum_r);
    rate_mag  = rate_neg ? GSUM_W'(-rate_sum_r) : GSUM_W'(rate_sum_r);
    roll_rnd  = {1'b0, roll_mag} + RHALF;
    rate_rnd  = {1'b0, rate_mag} + GHALF;
    roll_prod = (RQ_W+RSH)'(roll_rnd) * (RQ_W+RSH)'(RMUL);
    rate_prod = (GQ_W+GSH)'(rate_rnd) * (GQ_W+GSH)'(GMUL);
    roll_quo  = roll_prod[RQ_W+RSH-1:RSH];
    rate_quo  = rate_prod[GQ_W+GSH-1:GSH];
    avg_roll  = roll_neg ? -roll_quo[ROLL_W-1:0] : roll_quo[ROLL_W-1:0];
    avg_rate  = rate_neg ? -rate_quo[RATE_W-1:0] : rate_quo[RATE_W-1:0];
  end

endmodule

`default_nettype wire

>>> design/lamc_mode_ctrl.sv
// assist mode state machine and lock detect still counter
`default_nettype none

module lamc_mode_ctrl (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               tick_fire,
  input  wire logic [1:0]                         prediction,
  input  wire logic signed [lamc_pkg::ROLL_W-1:0] avg_roll,
  input  wire logic signed [lamc_pkg::RATE_W-1:0] avg_rate,
  input  wire logic signed [lamc_pkg::ROLL_W-1:0] band_high,
  input  wire logic signed [lamc_pkg::ROLL_W-1:0] band_low,
  input  wire logic signed [lamc_pkg::RATE_W-1:0] still_rate,
  input  wire logic [lamc_pkg::TICKS_W-1:0]       lock_ticks,
  output lamc_pkg::job_t                          job
);
  import lamc_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_band;
  logic             still;
  pred_t            pred;
  move_t            move;
  logic             missing;

  assign pred    = pred_t'(prediction);
  assign in_band = (avg_roll < band_high) && (avg_roll > band_low);
  assign still   = avg_rate < still_rate;

  // next mode and counter
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    case (mode_r)
      MODE_IDLE: begin
        if (pred == PRED_LIFTING) begin
          mode_nxt = MODE_LIFT;
        end else if (pred == PRED_FAST) begin
          mode_nxt = MODE_LOCK_DETECT;
        end
      end
      MODE_LIFT: begin
        if (in_band) begin
          mode_nxt = MODE_LOCK_DETECT;
        end else begin
          mode_nxt = MODE_IDLE;
          cnt_nxt  = '0;
        end
      end
      MODE_LOCK_DETECT: begin
        if (!in_band) begin
          mode_nxt = MODE_IDLE;
          cnt_nxt  = '0;
        end else begin
          if (!still) begin
            cnt_nxt = '0;
          end else if (cnt_r != CNT_MAX) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (cnt_nxt > CNT_W'(lock_ticks)) begin
            mode_nxt = MODE_LOCK;
          end
        end
      end
      MODE_LOCK: begin
        if (!in_band) begin
          mode_nxt = MODE_IDLE;
          cnt_nxt  = '0;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        cnt_nxt  = '0;
      end
    endcase
  end

  // move kind and flags for this tick
  always_comb begin
    move    = MOVE_NONE;
    missing = 1'b0;
    case (mode_r)
      MODE_IDLE: begin
        missing = (pred == PRED_MISSING);
      end
      MODE_LIFT: begin
        move = in_band ? MOVE_LIFT : MOVE_RELEASE;
      end
      MODE_LOCK_DETECT: begin
        move = in_band ? MOVE_NONE : MOVE_RELEASE;
      end
      MODE_LOCK: begin
        move = in_band ? MOVE_FOLLOW : MOVE_RELEASE;
      end
      default: begin
        move = MOVE_NONE;
      end
    endcase
  end

  always_comb begin
    job.move     = move;
    job.mode     = mode_nxt;
    job.missing  = missing;
    job.avg_roll = avg_roll;
  end

  // state advances on each tick transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= '0;
    end else if (tick_fire) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/lamc_target.sv
// job register, motor target arithmetic and result register
`default_nettype none

module lamc_target (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              job_valid,
  input  wire lamc_pkg::job_t                    job,
  output logic                                   job_ready,
  input  wire logic signed [lamc_pkg::POS_W-1:0] upper_limit,
  input  wire logic signed [lamc_pkg::POS_W-1:0] lower_limit,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_move_valid,
  output logic signed [lamc_pkg::POS_W-1:0]      out_move_target,
  output logic [1:0]                             out_mode,
  output logic                                   out_model_missing
);
  import lamc_pkg::*;

  localparam int unsigned SCL_W   = ROLL_W + 1 + 12;
  localparam int unsigned LOCK_SH = SCL_W + 1 + $clog2(LOCK_DIV);
  localparam logic [SCL_W:0] LOCK_HALF = (SCL_W+1)'(LOCK_DIV / 2);
  // reciprocal of the follow divisor, exact over the scaled roll range
  localparam logic [LOCK_SH-1:0] LOCK_MUL =
    LOCK_SH'(((64'd1 << LOCK_SH) + 64'(LOCK_DIV) - 64'd1) / 64'(LOCK_DIV));
  localparam logic signed [POS_W:0] POS_MIN = {2'b11, {(POS_W-1){1'b0}}};

  job_t                     job_r;
  logic                     job_valid_r;
  logic                     advance;

  logic                     out_valid_r;
  logic                     move_valid_r;
  logic signed [POS_W-1:0]  target_r;
  logic [1:0]               mode_r;
  logic                     missing_r;

  logic signed [ROLL_W:0]   diff;
  logic [ROLL_W:0]          diff_mag;
  logic [SCL_W:0]           scaled;
  logic [SCL_W+LOCK_SH:0]   lock_prod;
  logic [SCL_W:0]           quo;
  logic signed [POS_W:0]    offset;
  logic signed [POS_W:0]    upper_ext;
  logic signed [POS_W:0]    lower_ext;
  logic signed [POS_W:0]    follow;
  logic signed [POS_W:0]    lift;
  logic signed [POS_W-1:0]  follow_clamp;
  logic signed [POS_W-1:0]  lift_sat;
  logic signed [POS_W-1:0]  target;

  // stage hand-off
  assign advance   = !out_valid_r || out_ready;
  assign job_ready = !job_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (job_ready) begin
      job_valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      job_r <= job;
    end
  end

  // follow target: upper - round((1440 - roll) * 4096 / 9), clamped to the limits
  always_comb begin
    upper_ext = (POS_W+1)'(upper_limit);
    lower_ext = (POS_W+1)'(lower_limit);
    diff      = STAND_ROLL - (ROLL_W+1)'(job_r.avg_roll);
    diff_mag  = diff[ROLL_W] ? (ROLL_W+1)'(-diff) : (ROLL_W+1)'(diff);
    scaled    = {1'b0, diff_mag, 12'b0} + LOCK_HALF;
    lock_prod = (SCL_W+LOCK_SH+1)'(scaled) * (SCL_W+LOCK_SH+1)'(LOCK_MUL);
    quo       = lock_prod[SCL_W+LOCK_SH:LOCK_SH];
    offset    = diff[ROLL_W] ? -(POS_W+1)'(quo) : (POS_W+1)'(quo);
    follow    = upper_ext - offset;
    if (follow > upper_ext) begin
      follow_clamp = upper_limit;
    end else if (follow < lower_ext) begin
      follow_clamp = lower_limit;
    end else begin
      follow_clamp = follow[POS_W-1:0];
    end
  end

  // lift target with saturation at the bottom of the range
  always_comb begin
    lift     = upper_ext - LIFT_OFFSET;
    lift_sat = (lift < POS_MIN) ? POS_MIN[POS_W-1:0] : lift[POS_W-1:0];
  end

  always_comb begin
    case (job_r.move)
      MOVE_RELEASE: target = lower_limit;
      MOVE_LIFT:    target = lift_sat;
      MOVE_FOLLOW:  target = follow_clamp;
      default:      target = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= job_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && job_valid_r) begin
      move_valid_r <= (job_r.move != MOVE_NONE);
      target_r     <= target;
      mode_r       <= job_r.mode;
      missing_r    <= job_r.missing;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_move_valid    = move_valid_r;
  assign out_move_target   = target_r;
  assign out_mode          = mode_r;
  assign out_model_missing = missing_r;

endmodule

`default_nettype wire

>>> design/lift_assist_mode_controller_core.sv
// Lift assist mode controller: sample items (action 0) shift roll and gyro-x readings into
// AVG_DEPTH-deep windows whose averages are rounded to nearest; tick items (action 1) step
// the idle / lift / lock-detect / lock mode machine and give one result each, carrying an
// optional motor target (follow targets are clamped to the position limits). Samples give
// no result. One item is taken every cycle unless out_ready stalls the output; a tick's
// result passes the job register after the mode machine, then the result register after
// the target arithmetic. Configuration registers are written through cfg_we / cfg_index /
// cfg_wdata, by the user only while the block is idle; the block does not enforce it.
`default_nettype none

module lift_assist_mode_controller_core #(
  parameter int unsigned AVG_DEPTH = lamc_pkg::AVG_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [lamc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lamc_pkg::POS_W-1:0]         cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_action,
  input  wire logic signed [lamc_pkg::ROLL_W-1:0] in_roll_sample,
  input  wire logic signed [lamc_pkg::RATE_W-1:0] in_rate_sample,
  input  wire logic [1:0]                         in_prediction,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_move_valid,
  output logic signed [lamc_pkg::POS_W-1:0]       out_move_target,
  output logic [1:0]                              out_mode,
  output logic                                    out_model_missing
);
  import lamc_pkg::*;

  logic signed [POS_W-1:0]  upper_limit_r;
  logic signed [POS_W-1:0]  lower_limit_r;
  logic signed [ROLL_W-1:0] band_high_r;
  logic signed [ROLL_W-1:0] band_low_r;
  logic signed [RATE_W-1:0] still_rate_r;
  logic [TICKS_W-1:0]       lock_ticks_r;

  logic                     in_fire;
  logic                     sample_fire;
  logic                     tick_fire;
  logic signed [ROLL_W-1:0] avg_roll;
  logic signed [RATE_W-1:0] avg_rate;
  job_t                     job;
  logic                     job_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_limit_r <= '0;
      lower_limit_r <= '0;
      band_high_r   <= BAND_HIGH_RST;
      band_low_r    <= BAND_LOW_RST;
      still_rate_r  <= STILL_RATE_RST;
      lock_ticks_r  <= LOCK_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UPPER_LIMIT: upper_limit_r <= cfg_wdata;
        CFG_LOWER_LIMIT: lower_limit_r <= cfg_wdata;
        CFG_BAND_HIGH:   band_high_r   <= cfg_wdata[ROLL_W-1:0];
        CFG_BAND_LOW:    band_low_r    <= cfg_wdata[ROLL_W-1:0];
        CFG_STILL_RATE:  still_rate_r  <= cfg_wdata[RATE_W-1:0];
        CFG_LOCK_TICKS:  lock_ticks_r  <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // input transfer split by item kind
  assign in_ready    = job_ready;
  assign in_fire     = in_valid && in_ready;
  assign sample_fire = in_fire && !in_action;
  assign tick_fire   = in_fire && in_action;

  lamc_window #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_fire (sample_fire),
    .roll_sample (in_roll_sample),
    .rate_sample (in_rate_sample),
    .avg_roll    (avg_roll),
    .avg_rate    (avg_rate)
  );

  lamc_mode_ctrl u_mode_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_fire  (tick_fire),
    .prediction (in_prediction),
    .avg_roll   (avg_roll),
    .avg_rate   (avg_rate),
    .band_high  (band_high_r),
    .band_low   (band_low_r),
    .still_rate (still_rate_r),
    .lock_ticks (lock_ticks_r),
    .job        (job)
  );

  lamc_target u_target (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (tick_fire),
    .job               (job),
    .job_ready         (job_ready),
    .upper_limit       (upper_limit_r),
    .lower_limit       (lower_limit_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_move_valid    (out_move_valid),
    .out_move_target   (out_move_target),
    .out_mode          (out_mode),
    .out_model_missing (out_model_missing)
  );

endmodule

`default_nettype wire
